FILE: rtl/core/lfu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lfu_pkg;

  // Store geometry
  localparam int ENTRIES   = 16;
  localparam int PAGE_BITS = 16;
  localparam int IDX_W     = $clog2(ENTRIES);
  localparam int OCC_W     = $clog2(ENTRIES + 1);

  // Field widths
  localparam int IN_PAGE_W = 16;
  localparam int COUNT_W   = 16;
  localparam int STAMP_W   = 32;
  localparam int TOTAL_W   = 32;
  localparam int CAP_W     = 5;
  localparam int CMP_W     = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  localparam logic [CAP_W-1:0]   CAP_RESET = CAP_W'(4);
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // One slot of the page store
  typedef struct packed {
    logic [PAGE_BITS-1:0] page;
    logic [COUNT_W-1:0]   count;
    logic [STAMP_W-1:0]   stamp;
  } entry_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_WRITE = 3'b100
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/core/lfu_ifs.sv
`timescale 1ns / 1ps
`default_nettype none

// Page reference request channel
interface lfu_req_if;
  logic                           valid;
  logic                           ready;
  logic [lfu_pkg::IN_PAGE_W-1:0]  page_number;

  modport source (output valid, output page_number, input ready);
  modport sink   (input valid, input page_number, output ready);
endinterface

// Lookup result channel
interface lfu_rsp_if;
  logic                           valid;
  logic                           ready;
  logic                           was_hit;
  logic                           evicted_valid;
  logic [lfu_pkg::IN_PAGE_W-1:0]  evicted_page;
  logic [lfu_pkg::TOTAL_W-1:0]    hit_total;
  logic [lfu_pkg::TOTAL_W-1:0]    miss_total;

  modport source (output valid, output was_hit, output evicted_valid, output evicted_page,
                  output hit_total, output miss_total, input ready);
  modport sink   (input valid, input was_hit, input evicted_valid, input evicted_page,
                  input hit_total, input miss_total, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/lfu_page_replacement.sv
`timescale 1ns / 1ps
`default_nettype none

// Fully associative page store with least-frequently-used replacement. Each
// request names a page; the block answers with hit/miss, the evicted page (if
// any) and saturating hit and miss totals. Slots live in one synchronous
// memory with one read and one write port that is walked one slot per cycle:
// a request is accepted, all slots are scanned through the registered read
// port, and the chosen slot is written back, waiting while an earlier result
// is not yet taken. A new request is taken once the previous result is
// in the output register, even while that result still waits. The capacity
// register (cfg_wdata, reset 4) is clamped to 1..ENTRIES; write it only while
// the block is idle. No clearing pass is needed after reset.
module lfu_page_replacement (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic [lfu_pkg::CAP_W-1:0] cfg_wdata,
  lfu_req_if.sink                        in_req,
  lfu_rsp_if.source                      out_rsp
);

  localparam int IDX_W = lfu_pkg::IDX_W;
  localparam int CNT_W = lfu_pkg::IDX_W + 1;

  // Slot memory
  lfu_pkg::entry_t mem [lfu_pkg::ENTRIES];
  lfu_pkg::entry_t rd_data_r;

  // Control state
  lfu_pkg::state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]                 cnt_r, cnt_nxt;
  logic [lfu_pkg::ENTRIES-1:0]      valid_r, valid_nxt;
  logic [lfu_pkg::CAP_W-1:0]        cap_r, cap_nxt;
  logic [lfu_pkg::STAMP_W-1:0]      next_stamp_r, next_stamp_nxt;
  logic [lfu_pkg::TOTAL_W-1:0]      hits_r, hits_nxt;
  logic [lfu_pkg::TOTAL_W-1:0]      misses_r, misses_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic                             hit_found_r, hit_found_nxt;
  logic                             vic_found_r, vic_found_nxt;
  logic                             free_found_r, free_found_nxt;
  logic [lfu_pkg::OCC_W-1:0]        used_r, used_nxt;

  // Scan results and request payload
  logic [lfu_pkg::PAGE_BITS-1:0]    page_r, page_nxt;
  logic [IDX_W-1:0]                 hit_slot_r, hit_slot_nxt;
  logic [lfu_pkg::COUNT_W-1:0]      hit_count_r, hit_count_nxt;
  logic [lfu_pkg::STAMP_W-1:0]      hit_stamp_r, hit_stamp_nxt;
  logic [IDX_W-1:0]                 vic_slot_r, vic_slot_nxt;
  logic [lfu_pkg::COUNT_W-1:0]      vic_count_r, vic_count_nxt;
  logic [lfu_pkg::STAMP_W-1:0]      vic_age_r, vic_age_nxt;
  logic [lfu_pkg::PAGE_BITS-1:0]    vic_page_r, vic_page_nxt;
  logic [IDX_W-1:0]                 free_slot_r, free_slot_nxt;

  // Output payload
  logic                             o_hit_r, o_hit_nxt;
  logic                             o_ev_r, o_ev_nxt;
  logic [lfu_pkg::IN_PAGE_W-1:0]    o_ev_page_r, o_ev_page_nxt;

  // Memory access
  logic                             rd_en;
  logic [IDX_W-1:0]                 rd_addr;
  logic                             wr_en;
  logic [IDX_W-1:0]                 wr_addr;
  lfu_pkg::entry_t                  wr_data;

  // Combinational helpers
  logic                             accept;
  logic                             commit;
  logic                             scan_last;
  logic [IDX_W-1:0]                 scan_idx;
  logic [lfu_pkg::STAMP_W-1:0]      age;
  logic [lfu_pkg::CMP_W-1:0]        cap_cmp;
  logic [lfu_pkg::CMP_W-1:0]        eff_cap;
  logic                             evict;
  logic [IDX_W-1:0]                 slot;

  assign accept    = in_req.valid && in_req.ready;
  assign commit    = (state_r == lfu_pkg::ST_WRITE) && (!out_valid_r || out_rsp.ready);
  assign scan_last = (cnt_r == CNT_W'(lfu_pkg::ENTRIES));
  assign scan_idx  = IDX_W'(cnt_r - 1'b1);
  assign rd_addr   = cnt_r[IDX_W-1:0];
  assign rd_en     = (state_r == lfu_pkg::ST_SCAN) && !scan_last;
  assign age       = next_stamp_r - rd_data_r.stamp;

  // Clamp capacity to 1..ENTRIES
  assign cap_cmp = lfu_pkg::CMP_W'(cap_r);
  always_comb begin
    if (cap_cmp == '0) begin
      eff_cap = lfu_pkg::CMP_W'(1);
    end else if (cap_cmp > lfu_pkg::CMP_W'(lfu_pkg::ENTRIES)) begin
      eff_cap = lfu_pkg::CMP_W'(lfu_pkg::ENTRIES);
    end else begin
      eff_cap = cap_cmp;
    end
  end

  // Evict when full to capacity or no free slot is left
  assign evict = (lfu_pkg::CMP_W'(used_r) >= eff_cap) || !free_found_r;
  assign slot  = hit_found_r ? hit_slot_r : ((evict && vic_found_r) ? vic_slot_r : free_slot_r);

  assign in_req.ready          = (state_r == lfu_pkg::ST_IDLE);
  assign out_rsp.valid         = out_valid_r;
  assign out_rsp.was_hit       = o_hit_r;
  assign out_rsp.evicted_valid = o_ev_r;
  assign out_rsp.evicted_page  = o_ev_page_r;
  assign out_rsp.hit_total     = hits_r;
  assign out_rsp.miss_total    = misses_r;

  // Write-back word
  always_comb begin
    wr_en   = commit;
    wr_addr = slot;
    wr_data.page = page_r;
    if (hit_found_r) begin
      wr_data.count = (hit_count_r == lfu_pkg::COUNT_MAX) ? hit_count_r : hit_count_r + 1'b1;
      wr_data.stamp = hit_stamp_r;
    end else begin
      wr_data.count = lfu_pkg::COUNT_W'(1);
      wr_data.stamp = next_stamp_r;
    end
  end

  // Sequencer and scan datapath
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    valid_nxt      = valid_r;
    cap_nxt        = cfg_we ? cfg_wdata : cap_r;
    next_stamp_nxt = next_stamp_r;
    hits_nxt       = hits_r;
    misses_nxt     = misses_r;
    out_valid_nxt  = out_valid_r;
    hit_found_nxt  = hit_found_r;
    vic_found_nxt  = vic_found_r;
    free_found_nxt = free_found_r;
    used_nxt       = used_r;
    page_nxt       = page_r;
    hit_slot_nxt   = hit_slot_r;
    hit_count_nxt  = hit_count_r;
    hit_stamp_nxt  = hit_stamp_r;
    vic_slot_nxt   = vic_slot_r;
    vic_count_nxt  = vic_count_r;
    vic_age_nxt    = vic_age_r;
    vic_page_nxt   = vic_page_r;
    free_slot_nxt  = free_slot_r;
    o_hit_nxt      = o_hit_r;
    o_ev_nxt       = o_ev_r;
    o_ev_page_nxt  = o_ev_page_r;

    // Drop the result once taken
    if (out_valid_r && out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      lfu_pkg::ST_IDLE: begin
        // Latch the request and clear the scan trackers
        if (accept) begin
          page_nxt       = lfu_pkg::PAGE_BITS'(in_req.page_number);
          cnt_nxt        = '0;
          hit_found_nxt  = 1'b0;
          vic_found_nxt  = 1'b0;
          free_found_nxt = 1'b0;
          used_nxt       = '0;
          state_nxt      = lfu_pkg::ST_SCAN;
        end
      end
      lfu_pkg::ST_SCAN: begin
        // Examine the slot whose read data arrives this cycle
        if (cnt_r != '0) begin
          if (valid_r[scan_idx]) begin
            used_nxt = used_r + 1'b1;
            if (!hit_found_r && rd_data_r.page == page_r) begin
              hit_found_nxt = 1'b1;
              hit_slot_nxt  = scan_idx;
              hit_count_nxt = rd_data_r.count;
              hit_stamp_nxt = rd_data_r.stamp;
            end
            if (!vic_found_r || rd_data_r.count < vic_count_r ||
                (rd_data_r.count == vic_count_r && age > vic_age_r)) begin
              vic_found_nxt = 1'b1;
              vic_slot_nxt  = scan_idx;
              vic_count_nxt = rd_data_r.count;
              vic_age_nxt   = age;
              vic_page_nxt  = rd_data_r.page;
            end
          end else if (!free_found_r) begin
            free_found_nxt = 1'b1;
            free_slot_nxt  = scan_idx;
          end
        end
        // Advance the walk
        if (scan_last) begin
          state_nxt = lfu_pkg::ST_WRITE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      lfu_pkg::ST_WRITE: begin
        // Write back the slot and load the result register
        if (commit) begin
          out_valid_nxt = 1'b1;
          o_hit_nxt     = hit_found_r;
          if (hit_found_r) begin
            o_ev_nxt      = 1'b0;
            o_ev_page_nxt = '0;
            if (hits_r != lfu_pkg::TOTAL_MAX) begin
              hits_nxt = hits_r + 1'b1;
            end
          end else begin
            o_ev_nxt       = evict && vic_found_r;
            o_ev_page_nxt  = (evict && vic_found_r) ? lfu_pkg::IN_PAGE_W'(vic_page_r) : '0;
            valid_nxt[slot] = 1'b1;
            next_stamp_nxt = next_stamp_r + 1'b1;
            if (misses_r != lfu_pkg::TOTAL_MAX) begin
              misses_nxt = misses_r + 1'b1;
            end
          end
          state_nxt = lfu_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lfu_pkg::ST_IDLE;
      end
    endcase
  end

  // Slot memory: one read, one write port, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= lfu_pkg::ST_IDLE;
      cnt_r        <= '0;
      valid_r      <= '0;
      cap_r        <= lfu_pkg::CAP_RESET;
      next_stamp_r <= '0;
      hits_r       <= '0;
      misses_r     <= '0;
      out_valid_r  <= 1'b0;
      hit_found_r  <= 1'b0;
      vic_found_r  <= 1'b0;
      free_found_r <= 1'b0;
      used_r       <= '0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      valid_r      <= valid_nxt;
      cap_r        <= cap_nxt;
      next_stamp_r <= next_stamp_nxt;
      hits_r       <= hits_nxt;
      misses_r     <= misses_nxt;
      out_valid_r  <= out_valid_nxt;
      hit_found_r  <= hit_found_nxt;
      vic_found_r  <= vic_found_nxt;
      free_found_r <= free_found_nxt;
      used_r       <= used_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    page_r      <= page_nxt;
    hit_slot_r  <= hit_slot_nxt;
    hit_count_r <= hit_count_nxt;
    hit_stamp_r <= hit_stamp_nxt;
    vic_slot_r  <= vic_slot_nxt;
    vic_count_r <= vic_count_nxt;
    vic_age_r   <= vic_age_nxt;
    vic_page_r  <= vic_page_nxt;
    free_slot_r <= free_slot_nxt;
    o_hit_r     <= o_hit_nxt;
    o_ev_r      <= o_ev_nxt;
    o_ev_page_r <= o_ev_page_nxt;
  end

endmodule

`default_nettype wire
